// ===== rtl/nearby_duplicate_detector_defines.svh =====
`ifndef NEARBY_DUPLICATE_DETECTOR_DEFINES_SVH
`define NEARBY_DUPLICATE_DETECTOR_DEFINES_SVH

// same-cycle implication, skipped while reset is low
`define NDD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, skipped while reset is low
`define NDD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ndd_pkg.sv =====
`default_nettype none

package ndd_pkg;

    localparam int unsigned WINDOW_DEPTH = 64;
    localparam int unsigned VALUE_W      = 32;
    localparam int unsigned K_W          = 7;
    localparam int unsigned FILL_W       = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned CNT_W        = (FILL_W > K_W) ? FILL_W : K_W;
    localparam int unsigned GROUP        = 8;
    localparam int unsigned GROUPS       = (WINDOW_DEPTH + GROUP - 1) / GROUP;
    localparam int unsigned OUT_TDATA_W  = 8;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [FILL_W-1:0]         t_fill;
    typedef logic [CNT_W-1:0]          t_cnt;
    typedef logic [K_W-1:0]            t_window;

    typedef struct packed {
        logic valid;
        logic first;
    } t_stage_ctl;

endpackage

`default_nettype wire

// ===== rtl/ndd_cell.sv =====
`default_nettype none

// One window slot: holds a value, passes it to the older neighbor on each
// transfer, and flags a match against the incoming value.
module ndd_cell (
    input  wire             i_clk,
    input  wire             i_shift,
    input  wire             i_adv,
    input  wire             i_en,
    input  ndd_pkg::t_value i_prev,
    input  ndd_pkg::t_value i_cmp,
    output ndd_pkg::t_value o_value,
    output logic            o_match
);

    ndd_pkg::t_value r_value;
    logic            r_match;
    logic            n_match;

    assign n_match = i_en && (r_value == i_cmp);

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_value <= i_prev;
        end
        if (i_adv) begin
            r_match <= n_match;
        end
    end

    assign o_value = r_value;
    assign o_match = r_match;

endmodule

`default_nettype wire

// ===== rtl/ndd_reduce.sv =====
`default_nettype none

// First level of the match OR tree, registered per group of cells.
module ndd_reduce (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_adv,
    input  ndd_pkg::t_stage_ctl                i_ctl,
    input  wire  [ndd_pkg::WINDOW_DEPTH-1:0]   i_match,
    output ndd_pkg::t_stage_ctl                o_ctl,
    output logic [ndd_pkg::GROUPS-1:0]         o_group
);

    localparam int unsigned PAD_W = ndd_pkg::GROUPS * ndd_pkg::GROUP;

    logic [PAD_W-1:0]           w_padded;
    logic [ndd_pkg::GROUPS-1:0] n_group;
    logic [ndd_pkg::GROUPS-1:0] r_group;
    ndd_pkg::t_stage_ctl        r_ctl;

    assign w_padded = PAD_W'(i_match);

    always_comb begin
        for (int g = 0; g < int'(ndd_pkg::GROUPS); g++) begin
            n_group[g] = |w_padded[g*ndd_pkg::GROUP +: ndd_pkg::GROUP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_group <= n_group;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_group = r_group;

endmodule

`default_nettype wire

// ===== rtl/nearby_duplicate_detector.sv =====
// Channel  | Direction | Signals                              | Contents
// ---------+-----------+--------------------------------------+-------------------------------
// s        | in        | i_s_tvalid, o_s_tready, i_s_tdata,   | tdata: value; tuser: first
//          |           | i_s_tuser                            |
// m        | out       | o_m_tvalid, i_m_tready, o_m_tdata    | tdata: hit, found, zero pad
// cfg      | in        | i_cfg_valid, o_cfg_ready, i_cfg_data | window_k
//
// One item per cycle while the output register is empty or taken; results are registered
// in the cell compare at the transfer edge, then group OR, then final OR plus sticky flag.
// All window slots compare in parallel in the cell row; the row shifts once per transfer.
// Synchronous active-low reset clears fill count, sticky flag, window_k and
// stage valids; slot contents are left as they are and never read before written.
// o_s_tready drops only while the output register is full and not taken;
// the whole pipe then holds.
`default_nettype none

`include "nearby_duplicate_detector_defines.svh"

module nearby_duplicate_detector (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    input  wire  [ndd_pkg::VALUE_W-1:0]        i_s_tdata,   // [31:0] value
    input  wire                                i_s_tuser,   // [0] first
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    output logic [ndd_pkg::OUT_TDATA_W-1:0]    o_m_tdata,   // [0] hit, [1] found, rest 0
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [ndd_pkg::K_W-1:0]            i_cfg_data   // [6:0] window_k
);

    localparam int unsigned D = ndd_pkg::WINDOW_DEPTH;

    logic                 w_adv;
    logic                 w_acc;
    ndd_pkg::t_window     r_window_k;
    ndd_pkg::t_fill       r_fill;
    ndd_pkg::t_fill       n_fill;
    ndd_pkg::t_cnt        w_k_clamp;
    ndd_pkg::t_cnt        w_fill_eff;
    ndd_pkg::t_cnt        w_span;
    logic [D-1:0]         w_en;
    logic [D-1:0]         w_match;
    ndd_pkg::t_value      w_val [D];
    ndd_pkg::t_stage_ctl  r_s1;
    ndd_pkg::t_stage_ctl  n_s1;
    ndd_pkg::t_stage_ctl  w_s2;
    logic [ndd_pkg::GROUPS-1:0] w_group;
    logic                 r_out_valid;
    logic                 r_hit;
    logic                 r_found;
    logic                 r_seen;
    logic                 n_hit;
    logic                 n_found;

    assign w_adv      = !r_out_valid || i_m_tready;
    assign o_s_tready = w_adv;
    assign w_acc      = i_s_tvalid && w_adv;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_k <= '0;
        end else if (i_cfg_valid) begin
            r_window_k <= i_cfg_data;
        end
    end

    // compare span: min(clamped window, entries in current array)
    always_comb begin
        w_k_clamp = ndd_pkg::CNT_W'(r_window_k);
        if (w_k_clamp > ndd_pkg::CNT_W'(D)) begin
            w_k_clamp = ndd_pkg::CNT_W'(D);
        end
        w_fill_eff = i_s_tuser ? '0 : ndd_pkg::CNT_W'(r_fill);
        w_span     = (w_k_clamp < w_fill_eff) ? w_k_clamp : w_fill_eff;
    end

    always_comb begin
        n_fill = r_fill;
        if (w_acc) begin
            if (i_s_tuser) begin
                n_fill = ndd_pkg::FILL_W'(1);
            end else if (r_fill < ndd_pkg::FILL_W'(D)) begin
                n_fill = r_fill + ndd_pkg::FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // cell row, slot 0 newest
    for (genvar i = 0; i < int'(D); i++) begin : g_cell
        ndd_pkg::t_value w_prev;

        assign w_en[i] = ndd_pkg::CNT_W'(i) < w_span;

        if (i == 0) begin : g_head
            assign w_prev = ndd_pkg::t_value'(i_s_tdata);
        end else begin : g_body
            assign w_prev = w_val[i-1];
        end

        ndd_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_acc),
            .i_adv   (w_adv),
            .i_en    (w_en[i]),
            .i_prev  (w_prev),
            .i_cmp   (ndd_pkg::t_value'(i_s_tdata)),
            .o_value (w_val[i]),
            .o_match (w_match[i])
        );
    end

    assign n_s1.valid = w_acc;
    assign n_s1.first = i_s_tuser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else if (w_adv) begin
            r_s1 <= n_s1;
        end
    end

    ndd_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_ctl   (r_s1),
        .i_match (w_match),
        .o_ctl   (w_s2),
        .o_group (w_group)
    );

    // final OR and sticky flag
    assign n_hit   = |w_group;
    assign n_found = (!w_s2.first && r_seen) || n_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_seen      <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_s2.valid;
            if (w_s2.valid) begin
                r_seen <= n_found;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_s2.valid) begin
            r_hit   <= n_hit;
            r_found <= n_found;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(ndd_pkg::OUT_TDATA_W-2)'(0), r_found, r_hit};

    `NDD_ASSERT_NOW(a_hit_implies_found, i_clk, i_rst_n, o_m_tvalid,
        (!r_hit || r_found), "hit without found")
    `NDD_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1,
        (r_fill <= ndd_pkg::FILL_W'(D)), "fill count above depth")
    `NDD_ASSERT_NEXT(a_first_restarts, i_clk, i_rst_n, (w_acc && i_s_tuser),
        (r_fill == ndd_pkg::FILL_W'(1)), "array start did not restart fill count")
    `NDD_ASSERT_NEXT(a_zero_window, i_clk, i_rst_n, (w_acc && (r_window_k == '0)),
        (w_match == '0), "match with zero window")

endmodule

`default_nettype wire
